// ===== hdl/lmts_pkg.sv =====
package lmts_pkg;

   // Default phase and line lengths, in the unit of the cycles field of an item
   localparam int OAM_CYCLES_DEF         = 80;
   localparam int DRAW_CYCLES_DEF        = 172;
   localparam int HBLANK_CYCLES_DEF      = 204;
   localparam int VBLANK_LINE_CYCLES_DEF = 456;
   localparam int VISIBLE_LINES_DEF      = 144;

   // Fixed number of vblank lines per frame
   localparam int VBLANK_LINES = 10;

   localparam int ACCUM_W = 16;

   // Display modes as reported on the result channel
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_DRAW   = 2'd3;

   // Item operations
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_CONFIRM = 1'b1;

   // Configuration register indexes
   localparam logic CSR_LYC_COMPARE  = 1'b0;
   localparam logic CSR_STAT_ENABLES = 1'b1;

   localparam int CSR_DATA_W = 8;

   // STAT enable bits
   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_LYC    = 3;

   typedef struct packed {
      logic       operation;
      logic [7:0] cycles;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
      logic       frame_ready;
   } rsp_type;

   typedef struct packed {
      logic [7:0] lyc_compare;
      logic [3:0] stat_enables;
   } cfg_type;

endpackage

// ===== hdl/lmts_state.sv =====
module lmts_state import lmts_pkg::*; #(
   parameter int OAM_CYCLES         = OAM_CYCLES_DEF,
   parameter int DRAW_CYCLES        = DRAW_CYCLES_DEF,
   parameter int HBLANK_CYCLES      = HBLANK_CYCLES_DEF,
   parameter int VBLANK_LINE_CYCLES = VBLANK_LINE_CYCLES_DEF,
   parameter int VISIBLE_LINES      = VISIBLE_LINES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    commit,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [7:0] LAST_LINE_WRAP = 8'(VISIBLE_LINES + VBLANK_LINES);

   logic [ACCUM_W-1:0] accum_ff, accum_in;
   logic [1:0]         mode_ff, mode_in;
   logic [7:0]         line_ff, line_in;
   logic               coin_ff, coin_in;
   logic               any_last_ff, any_last_in;
   logic               frame_ready_ff, frame_ready_in;

   logic [ACCUM_W:0]   sum;
   logic [ACCUM_W-1:0] accum_sat;
   logic [ACCUM_W-1:0] phase_len;
   logic               phase_hit;
   logic [7:0]         line_inc;
   logic               any_now;
   logic               vblank_pulse;
   logic               stat_pulse;

   // Saturating add of elapsed cycles
   assign sum       = {1'b0, accum_ff} + {{(ACCUM_W + 1 - 8){1'b0}}, item.cycles};
   assign accum_sat = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
   assign line_inc  = line_ff + 8'd1;

   // Length of the current phase
   always_comb begin
      case (mode_ff)
         MODE_HBLANK: phase_len = ACCUM_W'(HBLANK_CYCLES);
         MODE_VBLANK: phase_len = ACCUM_W'(VBLANK_LINE_CYCLES);
         MODE_OAM:    phase_len = ACCUM_W'(OAM_CYCLES);
         default:     phase_len = ACCUM_W'(DRAW_CYCLES);
      endcase
   end

   assign phase_hit = (accum_sat >= phase_len);

   // One transition at most per item
   always_comb begin
      accum_in       = accum_ff;
      mode_in        = mode_ff;
      line_in        = line_ff;
      coin_in        = coin_ff;
      frame_ready_in = frame_ready_ff;
      vblank_pulse   = 1'b0;
      if (item.operation == OP_CONFIRM) begin
         frame_ready_in = 1'b0;
      end else begin
         accum_in = phase_hit ? accum_sat - phase_len : accum_sat;
         if (phase_hit) begin
            case (mode_ff)
               MODE_HBLANK: begin
                  line_in = line_inc;
                  if (line_inc < 8'(VISIBLE_LINES)) begin
                     mode_in = MODE_OAM;
                  end else begin
                     mode_in      = MODE_VBLANK;
                     vblank_pulse = 1'b1;
                  end
               end
               MODE_VBLANK: begin
                  line_in = line_inc;
                  if (line_inc == LAST_LINE_WRAP) begin
                     line_in        = 8'd0;
                     mode_in        = MODE_OAM;
                     frame_ready_in = 1'b1;
                  end
               end
               MODE_OAM: begin
                  coin_in = (line_ff == cfg.lyc_compare);
                  mode_in = MODE_DRAW;
               end
               default: begin
                  mode_in = MODE_HBLANK;
               end
            endcase
         end
      end
   end

   // STAT condition from the updated state, edge detected
   assign any_now = (cfg.stat_enables[STAT_EN_LYC]    && coin_in) ||
                    (cfg.stat_enables[STAT_EN_OAM]    && mode_in == MODE_OAM) ||
                    (cfg.stat_enables[STAT_EN_VBLANK] && mode_in == MODE_VBLANK) ||
                    (cfg.stat_enables[STAT_EN_HBLANK] && mode_in == MODE_HBLANK);

   always_comb begin
      any_last_in = any_last_ff;
      stat_pulse  = 1'b0;
      if (item.operation == OP_ADVANCE) begin
         any_last_in = any_now;
         stat_pulse  = any_now && !any_last_ff;
      end
   end

   assign result.mode        = mode_in;
   assign result.line        = line_in;
   assign result.coincidence = coin_in;
   assign result.vblank_irq  = vblank_pulse;
   assign result.stat_irq    = stat_pulse;
   assign result.frame_ready = frame_ready_in;

   // Timing state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff       <= '0;
         mode_ff        <= MODE_OAM;
         line_ff        <= '0;
         coin_ff        <= 1'b0;
         any_last_ff    <= 1'b0;
         frame_ready_ff <= 1'b0;
      end else if (commit) begin
         accum_ff       <= accum_in;
         mode_ff        <= mode_in;
         line_ff        <= line_in;
         coin_ff        <= coin_in;
         any_last_ff    <= any_last_in;
         frame_ready_ff <= frame_ready_in;
      end
   end

endmodule

// ===== hdl/lcd_mode_timing_sequencer_top.sv =====
// Pipeline: a req transfer passes the input register, then the result register,
//   before its rsp_valid; the timing state is updated between them.
// Throughput: one item per cycle while rsp_stall is low; each state update is committed before the next item.
// Reset (synchronous, active high): both stages empty, OAM search mode, line 0,
//   accumulator, flags and configuration registers cleared.
module lcd_mode_timing_sequencer_top import lmts_pkg::*; #(
   parameter int OAM_CYCLES         = OAM_CYCLES_DEF,
   parameter int DRAW_CYCLES        = DRAW_CYCLES_DEF,
   parameter int HBLANK_CYCLES      = HBLANK_CYCLES_DEF,
   parameter int VBLANK_LINE_CYCLES = VBLANK_LINE_CYCLES_DEF,
   parameter int VISIBLE_LINES      = VISIBLE_LINES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   cfg_type cfg_ff;
   rsp_type step_result;
   logic    out_free;
   logic    commit;
   logic    in_free;

   // Stage handshakes
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign commit    = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LYC_COMPARE:  cfg_ff.lyc_compare  <= csr_wr_data[7:0];
            CSR_STAT_ENABLES: cfg_ff.stat_enables <= csr_wr_data[3:0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   lmts_state #(
      .OAM_CYCLES         (OAM_CYCLES),
      .DRAW_CYCLES        (DRAW_CYCLES),
      .HBLANK_CYCLES      (HBLANK_CYCLES),
      .VBLANK_LINE_CYCLES (VBLANK_LINE_CYCLES),
      .VISIBLE_LINES      (VISIBLE_LINES)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hdl/lmts_checker.sv =====
module lmts_checker import lmts_pkg::*; #(
   parameter int VISIBLE_LINES = VISIBLE_LINES_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled request holds until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req changed while stalled");

   // A stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // Vblank is entered only on the first line past the visible area
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vblank_irq |->
         rsp_data.mode == MODE_VBLANK && rsp_data.line == 8'(VISIBLE_LINES))
      else $error("vblank interrupt outside vblank entry");

   // Vblank lines all lie past the visible area
   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode == MODE_VBLANK |->
         rsp_data.line >= 8'(VISIBLE_LINES))
      else $error("vblank on a visible line");

endmodule

bind lcd_mode_timing_sequencer_top lmts_checker #(
   .VISIBLE_LINES (VISIBLE_LINES)
) u_lmts_checker (.*);

// ===== sim/tb_lcd_mode_timing_sequencer_top.sv =====
module tb_lcd_mode_timing_sequencer_top;
   import lmts_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;
   localparam int ACCUM_MAX   = (1 << ACCUM_W) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // Predicted display timing state
   int         accum_cycles  = 0;
   logic [1:0] cur_mode      = MODE_OAM;
   logic [7:0] cur_line      = 8'd0;
   logic       cur_coinc     = 1'b0;
   logic       cond_prev     = 1'b0;
   logic       frame_pending = 1'b0;
   logic [7:0] lyc_value     = 8'd0;
   logic [3:0] stat_mask     = 4'd0;

   rsp_type expected_status[$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   // Idling controls for the sender and the receiver process
   bit sender_gaps    = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_start     = 1'b0;

   lcd_mode_timing_sequencer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mode/line update for one item; returns the status it should report
   function automatic rsp_type predict_line_timing(req_type item);
      rsp_type status;
      logic    cond_now;
      status = '0;
      if (item.operation == OP_CONFIRM) begin
         frame_pending = 1'b0;
      end else begin
         accum_cycles = accum_cycles + item.cycles;
         if (accum_cycles > ACCUM_MAX) accum_cycles = ACCUM_MAX;
         // at most one transition per item, surplus stays accumulated
         case (cur_mode)
            MODE_HBLANK: begin
               if (accum_cycles >= HBLANK_CYCLES_DEF) begin
                  accum_cycles = accum_cycles - HBLANK_CYCLES_DEF;
                  cur_line = cur_line + 8'd1;
                  if (cur_line < VISIBLE_LINES_DEF) begin
                     cur_mode = MODE_OAM;
                  end else begin
                     cur_mode = MODE_VBLANK;
                     status.vblank_irq = 1'b1;
                  end
               end
            end
            MODE_VBLANK: begin
               if (accum_cycles >= VBLANK_LINE_CYCLES_DEF) begin
                  accum_cycles = accum_cycles - VBLANK_LINE_CYCLES_DEF;
                  cur_line = cur_line + 8'd1;
                  if (cur_line == VISIBLE_LINES_DEF + VBLANK_LINES) begin
                     cur_line = 8'd0;
                     cur_mode = MODE_OAM;
                     frame_pending = 1'b1;
                  end
               end
            end
            MODE_OAM: begin
               if (accum_cycles >= OAM_CYCLES_DEF) begin
                  accum_cycles = accum_cycles - OAM_CYCLES_DEF;
                  cur_coinc = (cur_line == lyc_value);
                  cur_mode = MODE_DRAW;
               end
            end
            default: begin
               if (accum_cycles >= DRAW_CYCLES_DEF) begin
                  accum_cycles = accum_cycles - DRAW_CYCLES_DEF;
                  cur_mode = MODE_HBLANK;
               end
            end
         endcase
         // STAT line fires on the none-to-any edge of enabled conditions
         cond_now = (stat_mask[STAT_EN_LYC] && cur_coinc) ||
                    (stat_mask[STAT_EN_OAM] && cur_mode == MODE_OAM) ||
                    (stat_mask[STAT_EN_VBLANK] && cur_mode == MODE_VBLANK) ||
                    (stat_mask[STAT_EN_HBLANK] && cur_mode == MODE_HBLANK);
         status.stat_irq = cond_now && !cond_prev;
         cond_prev = cond_now;
      end
      status.mode        = cur_mode;
      status.line        = cur_line;
      status.coincidence = cur_coinc;
      status.frame_ready = frame_pending;
      return status;
   endfunction

   function automatic req_type make_item(logic op, logic [7:0] cycles);
      req_type item;
      item.operation = op;
      item.cycles    = cycles;
      return item;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected rsp transfer, queue depth", 0, 0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.mode != want.mode)
               report_mismatch("mode", rsp_data.mode, want.mode);
            if (rsp_data.line != want.line)
               report_mismatch("line", rsp_data.line, want.line);
            if (rsp_data.coincidence != want.coincidence)
               report_mismatch("coincidence", rsp_data.coincidence, want.coincidence);
            if (rsp_data.vblank_irq != want.vblank_irq)
               report_mismatch("vblank_irq", rsp_data.vblank_irq, want.vblank_irq);
            if (rsp_data.stat_irq != want.stat_irq)
               report_mismatch("stat_irq", rsp_data.stat_irq, want.stat_irq);
            if (rsp_data.frame_ready != want.frame_ready)
               report_mismatch("frame_ready", rsp_data.frame_ready, want.frame_ready);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lcd_mode_timing_sequencer_top verification failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, or one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            stall_left = HOLD_CYCLES;
            hold_start = 1'b0;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One req transfer; the prediction is queued at the accepting edge
   task automatic send_item(req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_status.push_back(predict_line_timing(item));
   endtask

   task automatic sender_gap(int len);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (len - 1) @(negedge clock);
   endtask

   task automatic send_burst(int count, int confirm_pct, int full_pct);
      logic [7:0] cycles;
      logic       op;
      repeat (count) begin
         if (sender_gaps && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 12));
         op = ($urandom_range(0, 99) < confirm_pct) ? OP_CONFIRM : OP_ADVANCE;
         cycles = ($urandom_range(0, 99) < full_pct) ? 8'hFF : 8'($urandom_range(0, 255));
         send_item(make_item(op, cycles));
      end
   endtask

   // Stop sending and wait until every expected status has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      if (index == CSR_LYC_COMPARE) lyc_value = value;
      else stat_mask = value[3:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_display_config(logic [7:0] lyc, logic [7:0] enables);
      drain_results();
      write_csr(CSR_LYC_COMPARE, lyc);
      write_csr(CSR_STAT_ENABLES, enables);
   endtask

   // Random compare line, mostly on a real line so coincidence hits
   task automatic random_config();
      logic [7:0] lyc;
      lyc = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 153));
      set_display_config(lyc, 8'($urandom_range(0, 255)));
   endtask

   // Phase stepping by hand: exact thresholds, surplus carry, confirm
   task automatic test_directed_timing();
      send_item(make_item(OP_CONFIRM, 8'h00));
      send_item(make_item(OP_ADVANCE, 8'h00));
      send_item(make_item(OP_ADVANCE, 8'd79));
      send_item(make_item(OP_ADVANCE, 8'd1));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'h00));
      send_item(make_item(OP_CONFIRM, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'hAA));
      send_item(make_item(OP_ADVANCE, 8'h55));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      // all enables on, compare on line 2
      set_display_config(8'd2, 8'h0F);
      send_item(make_item(OP_ADVANCE, 8'h00));
      send_item(make_item(OP_ADVANCE, 8'h00));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_CONFIRM, 8'h00));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      // compare never matches, STAT interrupts masked
      set_display_config(8'hFF, 8'h00);
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      set_display_config(8'd3, 8'h05);
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'hFF));
      send_item(make_item(OP_ADVANCE, 8'h01));
      send_item(make_item(OP_ADVANCE, 8'hFE));
   endtask

   task automatic test_random_mix();
      repeat (4) begin
         random_config();
         send_burst(30, 10, 20);
      end
   endtask

   // Long receiver hold while the sender keeps offering items
   task automatic test_backpressure();
      set_display_config(8'd5, 8'h0A);
      hold_start = 1'b1;
      sender_gaps = 1'b0;
      send_burst(40, 5, 60);
      sender_gaps = 1'b1;
      drain_results();
   endtask

   // Mostly full-size advances: crosses vblank and frame wrap
   task automatic test_frame_run();
      repeat (5) begin
         random_config();
         send_burst(100, 4, 85);
      end
   endtask

   // Last stretch with no idling on either side
   task automatic test_quiet_tail();
      set_display_config(8'd0, 8'h0F);
      sender_gaps = 1'b0;
      receiver_idles = 1'b0;
      send_burst(80, 5, 80);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_LYC_COMPARE;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_timing();
      test_random_mix();
      test_backpressure();
      test_frame_run();
      test_quiet_tail();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lcd_mode_timing_sequencer_top verification clean");
      end else begin
         $display("lcd_mode_timing_sequencer_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lmts_pkg.sv
hdl/lmts_state.sv
hdl/lcd_mode_timing_sequencer_top.sv
hdl/lmts_checker.sv
sim/tb_lcd_mode_timing_sequencer_top.sv
